@@ sv/gpns_pkg.sv @@
// package for the grid point neighbor search block
// types, codes and payload structs; no dependencies
`timescale 1ns / 1ps
package gpns_pkg;
  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_LIST    = 2'd1;
  localparam logic [1:0] CMD_CLOSEST = 2'd2;
  localparam logic [1:0] CMD_IGNORE  = 2'd3;

  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_INDEX = 2'd1;
  localparam logic [1:0] KIND_COUNT = 2'd2;
  localparam logic [1:0] KIND_DIST  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_CELL_FULL = 2'd1;
  localparam logic [1:0] ST_STORE_FULL = 2'd2;
  localparam logic [1:0] ST_TRUNC     = 2'd3;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        search_dist;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [9:0]  point_index;
    logic [15:0] value;
    logic [1:0]  status;
    logic        last;
  } out_item_t;

  // request from sequencer to the square root unit
  typedef struct packed {
    logic        start;
    logic [33:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic        done;
    logic [16:0] root;
  } sqrt_rsp_t;
endpackage

@@ sv/grid_point_neighbor_search.sv @@
// top level of the grid point neighbor search block
// depends on gpns_pkg and gpns_sqrt
`timescale 1ns / 1ps
// One item at a time under a sequencer. After reset the cell table is cleared
// one entry per cycle (GRID_MAX*GRID_MAX*SLOTS_PER_CELL entries, 1024 by default)
// before the first item is accepted. An insert takes accept, binning, a read and
// a check per slot probed (one to four, none when the point store is full) and
// the ack. A query takes accept, binning and setup, then walks (2N+1)^2 cells,
// N = ceil(dist*g/32768) capped at g/2: a cell step per cell, per occupied slot
// a slot read, point read, two squaring steps, compare and decide, and a slot read
// and point read for an empty slot, which ends a cell. One shared multiplier
// squares a coordinate difference per cycle; a closest query adds a bit-serial
// square root. Every result beat waits for the output register to be free.
module grid_point_neighbor_search #(
  parameter int GRID_MAX       = 16,
  parameter int SLOTS_PER_CELL = 4,
  parameter int MAX_POINTS     = 1024,
  parameter int MAX_LISTED     = 63
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  gpns_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output gpns_pkg::out_item_t  out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [4:0]           cfg_data_i
);
  localparam int CellW  = $clog2(GRID_MAX);
  localparam int SlotW  = (SLOTS_PER_CELL > 1) ? $clog2(SLOTS_PER_CELL) : 1;
  localparam int NCells = GRID_MAX * GRID_MAX;
  localparam int CAddrW = $clog2(NCells * SLOTS_PER_CELL);
  localparam int PIdxW  = $clog2(MAX_POINTS);
  localparam int PCntW  = PIdxW + 1;
  localparam int GW     = CellW + 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_BIN, S_INS_RD, S_INS_CHK, S_INS_ACK, S_QSETUP,
    S_CELL, S_SLOT_RD, S_PT_RD, S_DX, S_DY, S_CMP, S_EMIT, S_SQRT, S_FINAL
  } state_e;

  state_e state_q;
  logic [4:0] grid_q;
  gpns_pkg::in_item_t item_q;
  logic [PCntW-1:0] pcount_q;
  logic [CAddrW:0] clr_q;

  // cell slot memory: valid bit plus index
  logic [PIdxW:0] cmem [NCells*SLOTS_PER_CELL];
  logic [PIdxW:0] crd_q;
  logic [31:0]    pmem [MAX_POINTS];
  logic [31:0]    prd_q;

  logic [GW-1:0] g_eff, gx_q, gy_q, cx_q, cy_q, n_q, di_q, dj_q;
  logic [SlotW:0] slot_q;
  logic [PIdxW-1:0] idx_q;
  logic [33:0] dd_q, acc_q;
  logic [16:0] mul_a;
  logic [33:0] mul_p;
  logic [15:0] count_q;
  logic [6:0]  listed_q;
  logic        out_valid_q;
  gpns_pkg::out_item_t out_q;
  gpns_pkg::sqrt_req_t sreq;
  gpns_pkg::sqrt_rsp_t srsp;

  assign g_eff = (grid_q < 5'd2) ? GW'(2) :
                 ((32'(grid_q) > GRID_MAX) ? GW'(GRID_MAX) : GW'(grid_q));

  function automatic logic [GW-1:0] bin_c(input logic signed [15:0] c,
                                          input logic [GW-1:0] g);
    logic signed [17:0] v;
    logic [24:0] pr;
    begin
      v  = 18'(c) + 18'sd16384;
      pr = 25'(v[16:0]) * 25'(g);
      if (v < 0) bin_c = '0;
      else if ((pr >> 15) >= 25'(g)) bin_c = g - GW'(1);
      else bin_c = GW'(pr >> 15);
    end
  endfunction

  logic [CAddrW-1:0] cell_base, slot_addr;
  assign cell_base = CAddrW'((32'(cy_q) * 32'(g_eff) + 32'(cx_q)) * SLOTS_PER_CELL);
  assign slot_addr = cell_base + CAddrW'(slot_q);

  // shared squarer on the coordinate difference
  logic signed [16:0] diff;
  assign diff = (state_q == S_DX) ? 17'(item_q.pos_x) - 17'($signed(prd_q[31:16]))
                                  : 17'(item_q.pos_y) - 17'($signed(prd_q[15:0]));
  assign mul_a = diff[16] ? 17'(-diff) : 17'(diff);
  assign mul_p = 34'(mul_a) * 34'(mul_a);

  logic [GW-1:0] wrap_x, wrap_y;
  always_comb begin
    logic [GW+1:0] tx, ty, g1, g2;
    g1 = (GW+2)'(g_eff);
    g2 = (GW+2)'({g_eff, 1'b0});
    tx = (GW+2)'(gx_q) + (GW+2)'(di_q) + g1 - (GW+2)'(n_q);
    ty = (GW+2)'(gy_q) + (GW+2)'(dj_q) + g1 - (GW+2)'(n_q);
    if (tx >= g2) tx = tx - g2;
    if (tx >= g1) tx = tx - g1;
    if (ty >= g2) ty = ty - g2;
    if (ty >= g1) ty = ty - g1;
    wrap_x = tx[GW-1:0];
    wrap_y = ty[GW-1:0];
  end

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  // a result beat is loaded into the output register this cycle
  logic out_load;
  assign out_load = out_free &&
                    (state_q == S_INS_ACK || state_q == S_FINAL ||
                     (state_q == S_EMIT && acc_q < dd_q &&
                      item_q.cmd == gpns_pkg::CMD_LIST && 32'(listed_q) < MAX_LISTED));

  assign sreq.start = (state_q == S_SQRT) && acc_q[0];
  assign sreq.radicand = dd_q;

  gpns_sqrt u_sqrt (.clk_i, .rst_ni, .req_i(sreq), .rsp_o(srsp));

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // memories
  logic c_we;
  logic [CAddrW-1:0] c_wa;
  logic [PIdxW:0] c_wd;
  always_comb begin
    c_we = 1'b0; c_wa = slot_addr; c_wd = {1'b1, PIdxW'(pcount_q)};
    if (state_q == S_CLEAR) begin
      c_we = 1'b1; c_wa = clr_q[CAddrW-1:0]; c_wd = '0;
    end else if (state_q == S_INS_CHK && !crd_q[PIdxW]) begin
      c_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_we) cmem[c_wa] <= c_wd;
    crd_q <= cmem[slot_addr];
    if (state_q == S_BIN && pcount_q < PCntW'(MAX_POINTS) &&
        item_q.cmd == gpns_pkg::CMD_INSERT)
      pmem[pcount_q[PIdxW-1:0]] <= {item_q.pos_x, item_q.pos_y};
    // point read follows the slot just read, ready for the first squaring cycle
    prd_q <= pmem[crd_q[PIdxW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      grid_q <= 5'd16;
      pcount_q <= '0;
      clr_q <= '0;
      out_valid_q <= 1'b0;
      item_q <= '0;
      gx_q <= '0; gy_q <= '0; cx_q <= '0; cy_q <= '0; n_q <= '0;
      di_q <= '0; dj_q <= '0; slot_q <= '0; idx_q <= '0;
      dd_q <= '0; acc_q <= '0; count_q <= '0; listed_q <= '0; out_q <= '0;
    end else begin
      if (cfg_valid_i) grid_q <= cfg_data_i;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == (CAddrW+1)'(NCells*SLOTS_PER_CELL - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid_i) begin
            item_q <= in_data_i;
            state_q <= (in_data_i.cmd == gpns_pkg::CMD_IGNORE) ? S_IDLE : S_BIN;
          end
        end
        S_BIN: begin
          gx_q <= bin_c(item_q.pos_x, g_eff);
          gy_q <= bin_c(item_q.pos_y, g_eff);
          cx_q <= bin_c(item_q.pos_x, g_eff);
          cy_q <= bin_c(item_q.pos_y, g_eff);
          slot_q <= '0;
          if (item_q.cmd == gpns_pkg::CMD_INSERT) begin
            state_q <= (pcount_q >= PCntW'(MAX_POINTS)) ? S_INS_ACK : S_INS_RD;
          end else state_q <= S_QSETUP;
        end
        S_INS_RD: state_q <= S_INS_CHK;
        S_INS_CHK: begin
          if (!crd_q[PIdxW]) state_q <= S_INS_ACK;
          else if (32'(slot_q) == SLOTS_PER_CELL - 1) begin
            slot_q <= slot_q + 1'b1; state_q <= S_INS_ACK;
          end else begin
            slot_q <= slot_q + 1'b1; state_q <= S_INS_RD;
          end
        end
        S_INS_ACK: if (out_free) begin
          out_q.kind <= gpns_pkg::KIND_ACK;
          out_q.value <= '0;
          out_q.last <= 1'b1;
          if (pcount_q >= PCntW'(MAX_POINTS)) begin
            out_q.point_index <= '0;
            out_q.status <= gpns_pkg::ST_STORE_FULL;
          end else begin
            out_q.point_index <= 10'(pcount_q);
            out_q.status <= (32'(slot_q) == SLOTS_PER_CELL) ?
                            gpns_pkg::ST_CELL_FULL : gpns_pkg::ST_OK;
            pcount_q <= pcount_q + 1'b1;
          end
          state_q <= S_IDLE;
        end
        S_QSETUP: begin
          logic [20:0] t;
          t = 21'(item_q.search_dist) * 21'(g_eff) + 21'd32767;
          n_q <= (32'(t >> 15) > 32'(g_eff >> 1)) ? (g_eff >> 1) : GW'(t >> 15);
          dd_q <= 34'(item_q.search_dist) * 34'(item_q.search_dist);
          di_q <= '0; dj_q <= '0; count_q <= '0; listed_q <= '0;
          state_q <= S_CELL;
        end
        S_CELL: begin
          cx_q <= wrap_x; cy_q <= wrap_y; slot_q <= '0;
          state_q <= S_SLOT_RD;
        end
        S_SLOT_RD: state_q <= S_PT_RD;
        S_PT_RD: begin
          if (!crd_q[PIdxW]) begin
            // end of this cell
            if (di_q == n_q * 2) begin
              di_q <= '0;
              if (dj_q == n_q * 2) begin
                state_q <= (item_q.cmd == gpns_pkg::CMD_LIST) ? S_FINAL : S_SQRT;
                acc_q <= 34'd1;
              end else begin
                dj_q <= dj_q + 1'b1; state_q <= S_CELL;
              end
            end else begin
              di_q <= di_q + 1'b1; state_q <= S_CELL;
            end
          end else begin
            idx_q <= crd_q[PIdxW-1:0];
            state_q <= S_DX;
          end
        end
        S_DX: state_q <= S_DY;
        S_DY: state_q <= S_CMP;
        S_CMP: state_q <= S_EMIT;
        S_EMIT: begin
          if (!(acc_q < dd_q) || item_q.cmd != gpns_pkg::CMD_LIST ||
              32'(listed_q) >= MAX_LISTED || out_free) begin
            if (acc_q < dd_q) begin
              if (item_q.cmd == gpns_pkg::CMD_LIST) begin
                if (32'(listed_q) < MAX_LISTED) begin
                  out_q <= '{kind: gpns_pkg::KIND_INDEX, point_index: 10'(idx_q),
                             value: 16'd0, status: gpns_pkg::ST_OK, last: 1'b0};
                  listed_q <= listed_q + 1'b1;
                end
                if (count_q != 16'hffff) count_q <= count_q + 1'b1;
              end else dd_q <= acc_q;
            end
            if (32'(slot_q) == SLOTS_PER_CELL - 1) begin
              if (di_q == n_q * 2) begin
                di_q <= '0;
                if (dj_q == n_q * 2) begin
                  state_q <= (item_q.cmd == gpns_pkg::CMD_LIST) ? S_FINAL : S_SQRT;
                  acc_q <= 34'd1;
                end else begin
                  dj_q <= dj_q + 1'b1; state_q <= S_CELL;
                end
              end else begin
                di_q <= di_q + 1'b1; state_q <= S_CELL;
              end
            end else begin
              slot_q <= slot_q + 1'b1;
              state_q <= S_SLOT_RD;
            end
          end
        end
        S_SQRT: begin
          acc_q <= '0;
          if (srsp.done) state_q <= S_FINAL;
        end
        S_FINAL: if (out_free) begin
          out_q.point_index <= '0;
          out_q.last <= 1'b1;
          if (item_q.cmd == gpns_pkg::CMD_LIST) begin
            out_q.kind <= gpns_pkg::KIND_COUNT;
            out_q.value <= count_q;
            out_q.status <= (32'(count_q) > MAX_LISTED) ? gpns_pkg::ST_TRUNC
                                                        : gpns_pkg::ST_OK;
          end else begin
            out_q.kind <= gpns_pkg::KIND_DIST;
            out_q.value <= srsp.root[15:0];
            out_q.status <= gpns_pkg::ST_OK;
          end
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
      // squared distance accumulates over the two squaring states, S_DX then S_DY
      if (state_q == S_DX) acc_q <= mul_p;
      if (state_q == S_DY) acc_q <= acc_q + mul_p;
    end
  end
endmodule

@@ sv/gpns_sqrt.sv @@
// iterative integer square root, one result bit per cycle
// depends on gpns_pkg
`timescale 1ns / 1ps
module gpns_sqrt (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gpns_pkg::sqrt_req_t req_i,
  output gpns_pkg::sqrt_rsp_t rsp_o
);
  logic [33:0] rem_q, rem_d;
  logic [33:0] root_q, root_d;
  logic [33:0] bit_q, bit_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [33:0] trial;

  assign trial = root_q + bit_q;

  always_comb begin
    rem_d  = rem_q;
    root_d = root_q;
    bit_d  = bit_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = req_i.radicand;
      root_d = '0;
      bit_d  = 34'd1 << 32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_q >= trial) begin
        rem_d  = rem_q - trial;
        root_d = (root_q >> 1) + bit_q;
      end else begin
        root_d = root_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q == 34'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    bit_q  <= bit_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.root = root_q[16:0];
endmodule

@@ sv/gpns_checker.sv @@
// port level checks for grid_point_neighbor_search
// depends on gpns_pkg; bound to the top level below
`timescale 1ns / 1ps
module gpns_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input gpns_pkg::in_item_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input gpns_pkg::out_item_t out_data_o
);
  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");
  // a real command keeps the input stalled on the cycle after its beat
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.cmd != gpns_pkg::CMD_IGNORE |=> in_stall_o)
    else $error("second item taken back to back");
  // count and distance beats always close an item
  a_final_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.kind == gpns_pkg::KIND_COUNT ||
                    out_data_o.kind == gpns_pkg::KIND_DIST) |-> out_data_o.last)
    else $error("final beat without last");
  a_index_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == gpns_pkg::KIND_INDEX |-> !out_data_o.last)
    else $error("index beat flagged last");
endmodule

bind grid_point_neighbor_search gpns_checker u_gpns_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i, .out_valid_o, .out_stall_i,
  .out_data_o
);

@@ verif/grid_point_neighbor_search_checker.sv @@
// checker for the grid point neighbor search block: tracks the point store and
// cell table, predicts every result beat and compares; depends on gpns_pkg
`timescale 1ns / 1ps
module grid_point_neighbor_search_checker (
  input  logic                clk_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  gpns_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  gpns_pkg::out_item_t out_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [4:0]          cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  localparam int GridMax    = 16;
  localparam int SlotsCell  = 4;
  localparam int MaxPoints  = 1024;
  localparam int MaxListed  = 63;

  logic [4:0]   grid_reg;
  int           pt_x [MaxPoints];
  int           pt_y [MaxPoints];
  bit           slot_used [GridMax*GridMax][SlotsCell];
  int           slot_pt [GridMax*GridMax][SlotsCell];
  int           stored;
  gpns_pkg::out_item_t result_q [$];

  initial begin
    grid_reg = 5'd16;
    stored = 0;
    fail_count_o = 0;
    foreach (slot_used[c, k]) slot_used[c][k] = 1'b0;
  end

  assign pending_o = result_q.size();

  function automatic int cell_coord(int c, int g);
    int v, r;
    v = c + 16384;
    if (v < 0) return 0;
    r = (v * g) >> 15;
    return (r >= g) ? g - 1 : r;
  endfunction

  function automatic longint floor_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic gpns_pkg::out_item_t beat(logic [1:0] kind, int idx, int val,
                                               logic [1:0] st, logic lst);
    gpns_pkg::out_item_t o;
    o.kind = kind;
    o.point_index = idx[9:0];
    o.value = val[15:0];
    o.status = st;
    o.last = lst;
    return o;
  endfunction

  function automatic void add_beat(gpns_pkg::out_item_t b);
    result_q = {result_q, b};
  endfunction

  task automatic predict(input gpns_pkg::in_item_t it);
    int g, x, y, d, gx, gy, n, cx, cy, cell_ix, k, idx, listed, cnt;
    longint lim, s, dx, dy;
    bit placed;
    g = (grid_reg < 2) ? 2 : (grid_reg > GridMax) ? GridMax : int'(grid_reg);
    x = $signed(it.pos_x);
    y = $signed(it.pos_y);
    d = int'(it.search_dist);
    gx = cell_coord(x, g);
    gy = cell_coord(y, g);
    lim = longint'(d) * d;
    if (it.cmd == gpns_pkg::CMD_INSERT) begin
      if (stored >= MaxPoints) begin
        add_beat(beat(gpns_pkg::KIND_ACK, 0, 0, gpns_pkg::ST_STORE_FULL, 1'b1));
        return;
      end
      idx = stored;
      stored++;
      pt_x[idx] = x;
      pt_y[idx] = y;
      cell_ix = gy * g + gx;
      placed = 1'b0;
      for (k = 0; k < SlotsCell && !placed; k++) begin
        if (!slot_used[cell_ix][k]) begin
          slot_used[cell_ix][k] = 1'b1;
          slot_pt[cell_ix][k] = idx;
          placed = 1'b1;
        end
      end
      add_beat(beat(gpns_pkg::KIND_ACK, idx, 0,
                    placed ? gpns_pkg::ST_OK : gpns_pkg::ST_CELL_FULL, 1'b1));
      return;
    end
    if (it.cmd != gpns_pkg::CMD_LIST && it.cmd != gpns_pkg::CMD_CLOSEST) return;
    n = (d * g + 32767) >> 15;
    if (n > (g >> 1)) n = g >> 1;
    listed = 0;
    cnt = 0;
    for (int j = -n; j <= n; j++) begin
      for (int i = -n; i <= n; i++) begin
        cx = (gx + i + g) % g;
        cy = (gy + j + g) % g;
        cell_ix = cy * g + cx;
        // scan stops at the first empty slot of the cell
        for (k = 0; k < SlotsCell && slot_used[cell_ix][k]; k++) begin
          idx = slot_pt[cell_ix][k];
          dx = longint'(x) - pt_x[idx];
          dy = longint'(y) - pt_y[idx];
          s = dx * dx + dy * dy;
          if (s < lim) begin
            if (it.cmd == gpns_pkg::CMD_LIST) begin
              if (listed < MaxListed) begin
                add_beat(beat(gpns_pkg::KIND_INDEX, idx, 0, gpns_pkg::ST_OK, 1'b0));
                listed++;
              end
              if (cnt < 65535) cnt++;
            end else begin
              lim = s;
            end
          end
        end
      end
    end
    if (it.cmd == gpns_pkg::CMD_LIST)
      add_beat(beat(gpns_pkg::KIND_COUNT, 0, cnt,
                    (cnt > MaxListed) ? gpns_pkg::ST_TRUNC : gpns_pkg::ST_OK, 1'b1));
    else
      add_beat(beat(gpns_pkg::KIND_DIST, 0, int'(floor_root(lim)),
                    gpns_pkg::ST_OK, 1'b1));
  endtask

  always @(posedge clk_i) begin
    gpns_pkg::out_item_t want;
    if (cfg_valid_i && cfg_ready_i) grid_reg <= cfg_data_i;
    if (in_valid_i && !in_stall_i) predict(in_data_i);
    if (out_valid_i && !out_stall_i) begin
      if (result_q.size() == 0) begin
        fail_count_o++;
        if (fail_count_o <= 10)
          $display("unexpected result beat %p", out_data_i);
      end else begin
        want = result_q.pop_front();
        if (want !== out_data_i) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("result mismatch: expected %p, got %p", want, out_data_i);
        end
      end
    end
  end
endmodule

@@ verif/grid_point_neighbor_search_test.sv @@
// testbench top for the grid point neighbor search block: makes inserts and
// radius queries over several grid sizes; depends on gpns_pkg and the checker
`timescale 1ns / 1ps
module grid_point_neighbor_search_test;
  localparam int CycleLimit = 20000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  gpns_pkg::in_item_t  in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  gpns_pkg::out_item_t out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [4:0]  cfg_data_i = '0;
  int          fail_count, pending;
  int          cycles = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;
  int          inserts_sent = 0;
  int          recent_x [32];
  int          recent_y [32];

  always #5 clk_i = ~clk_i;

  grid_point_neighbor_search dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  grid_point_neighbor_search_checker checker_i (
    .clk_i, .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: random stall per beat, plus one long hold on request
  initial begin
    int w;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (600) @(posedge clk_i);
        hold_req = 1'b0;
      end
      w = quiet ? 0 : $urandom_range(0, 6);
      if (w > 0) begin
        out_stall_i <= 1'b1;
        repeat (w) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic send(input logic [1:0] cmd, input int x, input int y, input int d);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{cmd: cmd, pos_x: x[15:0], pos_y: y[15:0], search_dist: d[15:0]};
    if (cmd == gpns_pkg::CMD_INSERT) begin
      recent_x[inserts_sent % 32] = x;
      recent_y[inserts_sent % 32] = y;
      inserts_sent++;
    end
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_grid(input logic [4:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic int rand_coord();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 65535);
    return int'($urandom_range(0, 32768)) - 16384;
  endfunction

  task automatic send_random();
    int r, x, y, d, p;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      send(gpns_pkg::CMD_INSERT, rand_coord(), rand_coord(), $urandom_range(0, 65535));
      return;
    end
    if (r >= 96) begin
      send(gpns_pkg::CMD_IGNORE, rand_coord(), rand_coord(), $urandom_range(0, 65535));
      return;
    end
    // queries mostly around a recently inserted point
    if (inserts_sent > 0 && $urandom_range(0, 3) != 0) begin
      p = $urandom_range(0, (inserts_sent < 32 ? inserts_sent : 32) - 1);
      x = recent_x[p] + int'($urandom_range(0, 2000)) - 1000;
      y = recent_y[p] + int'($urandom_range(0, 2000)) - 1000;
    end else begin
      x = rand_coord();
      y = rand_coord();
    end
    p = $urandom_range(0, 99);
    d = (p < 85) ? $urandom_range(0, 3000) :
        (p < 95) ? $urandom_range(0, 32768) : $urandom_range(0, 65535);
    send((r < 70) ? gpns_pkg::CMD_LIST : gpns_pkg::CMD_CLOSEST, x, y, d);
  endtask

  initial begin
    logic [4:0] grids [8] = '{5'd2, 5'd31, 5'd0, 5'd1, 5'd7, 5'd16, 5'd3, 5'd12};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_grid(5'd16);
    send(gpns_pkg::CMD_INSERT, -16384, -16384, 0);
    send(gpns_pkg::CMD_INSERT, 16384, 16384, 65535);
    send(gpns_pkg::CMD_INSERT, 16383, -16384, 0);
    send(gpns_pkg::CMD_INSERT, -32768, 32767, 0);
    repeat (5) send(gpns_pkg::CMD_INSERT, 0, 0, 0);
    send(gpns_pkg::CMD_LIST, 0, 0, 0);
    send(gpns_pkg::CMD_LIST, 0, 0, 1);
    send(gpns_pkg::CMD_LIST, -16384, -16384, 65535);
    send(gpns_pkg::CMD_CLOSEST, 100, 100, 32768);
    send(gpns_pkg::CMD_CLOSEST, 0, 0, 0);
    send(gpns_pkg::CMD_IGNORE, 0, 0, 0);
    send(gpns_pkg::CMD_LIST, 16384, 16384, 32768);
    send(gpns_pkg::CMD_CLOSEST, -1, -1, 65535);
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      write_grid(grids[ph]);
      if (ph == 4) begin
        // inserts back up behind a long output hold
        quiet = 1'b1;
        hold_req = 1'b1;
        repeat (30) send(gpns_pkg::CMD_INSERT, rand_coord(), rand_coord(), 0);
        quiet = 1'b0;
      end
      for (int i = 0; i < 53; i++) begin
        quiet = (ph % 2 == 1) && (i < 20);
        send_random();
        if (i == 27) wait_idle();
      end
      quiet = 1'b0;
      wait_idle();
    end

    // query the crowded grid at the end
    write_grid(5'd16);
    send(gpns_pkg::CMD_LIST, 0, 0, 32768);
    send(gpns_pkg::CMD_CLOSEST, 0, 0, 32768);
    send(gpns_pkg::CMD_LIST, 1000, -1000, 2000);
    send(gpns_pkg::CMD_INSERT, 0, 0, 0);
    wait_idle();

    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule

@@ filelist.f @@
sv/gpns_pkg.sv
sv/gpns_sqrt.sv
sv/grid_point_neighbor_search.sv
sv/gpns_checker.sv
verif/grid_point_neighbor_search_checker.sv
verif/grid_point_neighbor_search_test.sv
